### rtl/dpfr_pkg.sv
// dpfr_pkg: request and response types, field widths and codes of the
// demand paging fault resolver
// no dependencies
package dpfr_pkg;

    // field widths
    localparam int ADDR_W    = 32;
    localparam int SZ_W      = 21;
    localparam int SLOT_W    = 3;
    localparam int PERM_W    = 3;
    localparam int BYTES_W   = 13;
    localparam int VERDICT_W = 2;
    localparam int CFG_W     = 4;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FAULT = 1'b1;

    // verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_MAP     = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_INVALID = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_LOADED  = 2'd2;

    typedef struct packed {
        logic              operation;
        logic [SLOT_W-1:0] segment_slot;
        logic [ADDR_W-1:0] address;
        logic [SZ_W-1:0]   mem_bytes;
        logic [SZ_W-1:0]   file_bytes;
        logic [ADDR_W-1:0] file_start;
        logic [PERM_W-1:0] access_perm;
    } t_req;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [SLOT_W-1:0]    segment_hit;
        logic [ADDR_W-1:0]    page_address;
        logic [ADDR_W-1:0]    file_position;
        logic [BYTES_W-1:0]   read_bytes;
        logic [BYTES_W-1:0]   zero_bytes;
        logic [PERM_W-1:0]    page_perm;
    } t_rsp;

endpackage

### rtl/dpfr_stream_if.sv
// dpfr_stream_if: valid/ready channel carrying one request or response
// payload type is set by the instantiating level (dpfr_pkg types)
interface dpfr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/dpfr_page_map.sv
// dpfr_page_map: single bit per page mapped table, one write and one
// registered read per cycle; no dependencies
module dpfr_page_map #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata
);

    logic r_mem [DEPTH];
    logic r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/demand_paging_fault_resolver_unit.sv
// demand_paging_fault_resolver_unit: segment table scan and page fault resolution
// depends on dpfr_pkg, dpfr_stream_if and dpfr_page_map
// fault: segments are scanned in slot order, one subtract/compare per cycle, up to the
//   first hit, then S_PAGE and, for a page inside the row, S_CHECK; no hit ends in S_DONE
// load: the slot's mapped bits are wiped, one bit per cycle, before the response
// a new request can be taken in the cycle response valid rises; a held response stalls it
// reset: synchronous; a clearing pass sweeps the whole mapped table
//   before the first request is taken
module demand_paging_fault_resolver_unit #(
    parameter int NUM_SEGMENTS      = 8,
    parameter int PAGE_BYTES        = 4096,
    parameter int PAGES_PER_SEGMENT = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [dpfr_pkg::CFG_W-1:0] i_cfg_wdata,
    dpfr_stream_if.sink                i_req,
    dpfr_stream_if.source              o_rsp
);
    import dpfr_pkg::*;

    localparam int SEG_W     = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
    localparam int CNT_W     = $clog2(NUM_SEGMENTS + 1);
    localparam int MAP_DEPTH = NUM_SEGMENTS * PAGES_PER_SEGMENT;
    localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int PG_SH     = $clog2(PAGE_BYTES);
    localparam logic [SZ_W-1:0] PS_SZ   = SZ_W'(PAGE_BYTES);
    localparam logic [SZ_W-1:0] PG_MASK = SZ_W'(PAGE_BYTES - 1);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_WIPE  = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_PAGE  = 7'b0010000,
        S_CHECK = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // configuration and segment table
    logic [CFG_W-1:0]  r_seg_count;
    logic [ADDR_W-1:0] r_seg_base   [NUM_SEGMENTS];
    logic [SZ_W-1:0]   r_seg_ms     [NUM_SEGMENTS];
    logic [SZ_W-1:0]   r_seg_fs     [NUM_SEGMENTS];
    logic [ADDR_W-1:0] r_seg_foff   [NUM_SEGMENTS];
    logic [PERM_W-1:0] r_seg_perm   [NUM_SEGMENTS];

    // sequencer registers
    logic [ADDR_W-1:0] r_addr;
    logic [SEG_W-1:0]  r_scan_idx;
    logic [CNT_W-1:0]  r_scan_lim;
    logic [MAP_AW-1:0] r_row_base;
    logic [SZ_W-1:0]   r_diff;
    logic [MAP_AW-1:0] r_map_addr;
    logic [MAP_AW-1:0] r_wipe_addr;
    logic [MAP_AW-1:0] r_wipe_end;
    logic [ADDR_W-1:0] r_paddr;
    logic [ADDR_W-1:0] r_fpos;
    logic [SZ_W:0]     r_left;
    logic [SZ_W-1:0]   r_ml_page;
    logic [SZ_W:0]     r_ml_file;
    t_rsp              r_res;
    t_rsp              r_rsp;
    logic              r_rsp_valid;

    // combinational signals
    logic              req_fire;
    logic              slot_ok;
    logic [SEG_W-1:0]  slot_idx;
    logic [MAP_AW-1:0] slot_row;
    logic [CNT_W-1:0]  lim;
    logic [ADDR_W-1:0] d_base;
    logic [SZ_W-1:0]   d_ms;
    logic [SZ_W-1:0]   d_fs;
    logic [ADDR_W-1:0] d_foff;
    logic [PERM_W-1:0] d_perm;
    logic [ADDR_W:0]   scan_diff;
    logic              scan_hit;
    logic              scan_last;
    logic [SZ_W-PG_SH-1:0] page;
    logic [SZ_W-1:0]   page_off;
    logic              page_big;
    logic [MAP_AW-1:0] map_raddr;
    logic              map_q;
    logic              map_we;
    logic [MAP_AW-1:0] map_waddr;
    logic              map_wdata;
    logic              has_file;
    logic [SZ_W-1:0]   rd;
    logic [SZ_W-1:0]   room;
    logic [SZ_W-1:0]   mfl;
    logic [SZ_W-1:0]   zr;
    logic              out_free;

    assign req_fire    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;
    assign out_free    = !r_rsp_valid || o_rsp.ready;

    // load slot decode
    assign slot_ok  = 32'(i_req.data.segment_slot) < 32'(NUM_SEGMENTS);
    assign slot_idx = SEG_W'(i_req.data.segment_slot);
    assign slot_row = MAP_AW'(32'(i_req.data.segment_slot) * 32'(PAGES_PER_SEGMENT));
    assign lim      = (32'(r_seg_count) > 32'(NUM_SEGMENTS)) ? CNT_W'(NUM_SEGMENTS)
                                                             : CNT_W'(r_seg_count);

    // descriptor of the slot under the scan pointer
    assign d_base = r_seg_base[r_scan_idx];
    assign d_ms   = r_seg_ms[r_scan_idx];
    assign d_fs   = r_seg_fs[r_scan_idx];
    assign d_foff = r_seg_foff[r_scan_idx];
    assign d_perm = r_seg_perm[r_scan_idx];

    // shared range compare unit
    assign scan_diff = {1'b0, r_addr} - {1'b0, d_base};
    assign scan_hit  = !scan_diff[ADDR_W]
                       && (scan_diff[ADDR_W-1:0] < ADDR_W'(d_ms));
    assign scan_last = (CNT_W'(r_scan_idx) + CNT_W'(1)) == r_scan_lim;

    // page number and table address
    assign page      = r_diff[SZ_W-1:PG_SH];
    assign page_off  = r_diff & ~PG_MASK;
    assign page_big  = 32'(page) >= 32'(PAGES_PER_SEGMENT);
    assign map_raddr = r_row_base + MAP_AW'(page);

    // byte counts of the mapped page
    assign has_file = !r_left[SZ_W] && (r_left[SZ_W-1:0] != '0);
    assign rd       = (r_left[SZ_W-1:0] > PS_SZ) ? PS_SZ : r_left[SZ_W-1:0];
    assign room     = PS_SZ - rd;
    assign mfl      = r_ml_file[SZ_W] ? '0 : r_ml_file[SZ_W-1:0];

    always_comb begin
        if (has_file) begin
            zr = (room > mfl) ? mfl : room;
        end else begin
            zr = (r_ml_page > PS_SZ) ? PS_SZ : r_ml_page;
        end
    end

    // mapped table write port
    always_comb begin
        map_we    = 1'b0;
        map_waddr = r_wipe_addr;
        map_wdata = 1'b0;
        if (r_state == S_CLEAR || r_state == S_WIPE) begin
            map_we = 1'b1;
        end else if (r_state == S_CHECK && !map_q) begin
            map_we    = 1'b1;
            map_waddr = r_map_addr;
            map_wdata = 1'b1;
        end
    end

    dpfr_page_map #(
        .DEPTH (MAP_DEPTH),
        .AW    (MAP_AW)
    ) u_page_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_q)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_wipe_addr == r_wipe_end) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (req_fire) begin
                    if (i_req.data.operation == OP_LOAD) begin
                        n_state = slot_ok ? S_WIPE : S_DONE;
                    end else begin
                        n_state = (lim == '0) ? S_DONE : S_SCAN;
                    end
                end
            end
            S_WIPE: begin
                if (r_wipe_addr == r_wipe_end) begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_state = S_PAGE;
                end else if (scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_PAGE: begin
                n_state = page_big ? S_DONE : S_CHECK;
            end
            S_CHECK: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_seg_count <= '0;
            r_wipe_addr <= '0;
            r_wipe_end  <= MAP_AW'(MAP_DEPTH - 1);
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_seg_count <= i_cfg_wdata;
            end
            if (r_state == S_CLEAR || r_state == S_WIPE) begin
                r_wipe_addr <= r_wipe_addr + MAP_AW'(1);
            end else if (req_fire && i_req.data.operation == OP_LOAD) begin
                r_wipe_addr <= slot_row;
                r_wipe_end  <= slot_row + MAP_AW'(PAGES_PER_SEGMENT - 1);
            end
            if (r_state == S_DONE && out_free) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // descriptor table writes
    always_ff @(posedge i_clk) begin
        if (req_fire && i_req.data.operation == OP_LOAD && slot_ok) begin
            r_seg_base[slot_idx] <= i_req.data.address;
            r_seg_ms[slot_idx]   <= i_req.data.mem_bytes;
            r_seg_fs[slot_idx]   <= i_req.data.file_bytes;
            r_seg_foff[slot_idx] <= i_req.data.file_start;
            r_seg_perm[slot_idx] <= i_req.data.access_perm;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_rsp <= r_res;
        end
        unique case (r_state)
            S_IDLE: begin
                r_addr     <= i_req.data.address;
                r_scan_idx <= '0;
                r_row_base <= '0;
                r_scan_lim <= lim;
                if (i_req.data.operation == OP_LOAD) begin
                    r_res <= '{verdict: VERDICT_LOADED,
                               segment_hit: i_req.data.segment_slot, default: '0};
                end else begin
                    r_res <= '{verdict: VERDICT_INVALID, default: '0};
                end
            end
            S_SCAN: begin
                r_diff <= scan_diff[SZ_W-1:0];
                if (!scan_hit) begin
                    r_scan_idx <= r_scan_idx + SEG_W'(1);
                    r_row_base <= r_row_base + MAP_AW'(PAGES_PER_SEGMENT);
                end
            end
            S_PAGE: begin
                r_map_addr <= map_raddr;
                r_paddr    <= d_base + ADDR_W'(page_off);
                r_fpos     <= d_foff + ADDR_W'(page_off);
                r_left     <= {1'b0, d_fs} - {1'b0, page_off};
                r_ml_page  <= d_ms - page_off;
                r_ml_file  <= {1'b0, d_ms} - {1'b0, d_fs};
                r_res      <= '{verdict: VERDICT_INVALID,
                                segment_hit: SLOT_W'(r_scan_idx), default: '0};
            end
            S_CHECK: begin
                if (!map_q) begin
                    r_res.verdict       <= VERDICT_MAP;
                    r_res.page_address  <= r_paddr;
                    r_res.file_position <= has_file ? r_fpos : '0;
                    r_res.read_bytes    <= has_file ? BYTES_W'(rd) : '0;
                    r_res.zero_bytes    <= BYTES_W'(zr);
                    r_res.page_perm     <= d_perm;
                end
            end
            S_CLEAR, S_WIPE, S_DONE: begin
                r_diff <= r_diff;
            end
            default: begin
                r_diff <= r_diff;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // the scan pointer stays below the number of segments in use
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CNT_W'(r_scan_idx) < r_scan_lim))
        else $error("scan pointer beyond segment count");

    // the checked mapped bit belongs to the row of the hit segment
    a_map_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK)
        |-> ((32'(r_map_addr) - 32'(r_row_base)) < 32'(PAGES_PER_SEGMENT)))
        else $error("mapped bit address outside segment row");

    // copied and cleared bytes never exceed one page
    a_page_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && !map_q)
        |-> (((has_file ? 32'(rd) : 32'd0) + 32'(zr)) <= 32'(PAGE_BYTES)))
        else $error("page byte counts exceed page size");

    // a response appears only after the sequencer finished a request
    a_rsp_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rsp_valid) |-> $past(r_state == S_DONE))
        else $error("response raised outside completion");
`endif

endmodule

### verif/testbench.sv
// testbench: self-checking bench for demand_paging_fault_resolver_unit
// drives descriptor loads and page faults over dpfr_stream_if channels and checks
// every response against an in-bench predictor; depends on dpfr_pkg and dpfr_stream_if
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dpfr_pkg::*;

    localparam int NUM_SEGMENTS      = 8;
    localparam int PAGE_BYTES        = 4096;
    localparam int PAGES_PER_SEGMENT = 256;
    localparam int MAX_SEG_BYTES     = 1048576;
    localparam int PHASES            = 12;
    localparam int PHASE_ITEMS       = 160;
    localparam int WATCHDOG_LIMIT    = 10000;
    localparam int LONG_HOLD_CYCLES  = 600;
    localparam int MAX_REPORTS       = 40;

    // scoreboard: mirror of the segment table and mapped bits, queue of awaited responses
    class paging_scoreboard;
        bit [CFG_W-1:0]  segments_in_use;
        bit [ADDR_W-1:0] seg_base       [NUM_SEGMENTS];
        bit [SZ_W-1:0]   seg_mem_size   [NUM_SEGMENTS];
        bit [SZ_W-1:0]   seg_file_size  [NUM_SEGMENTS];
        bit [ADDR_W-1:0] seg_file_start [NUM_SEGMENTS];
        bit [PERM_W-1:0] seg_perm       [NUM_SEGMENTS];
        bit              page_mapped    [NUM_SEGMENTS][PAGES_PER_SEGMENT];
        t_rsp            awaited_rsp    [$];
        int              errors;
        int              loads;
        int              maps;
        int              invalids;

        function new();
            segments_in_use = '0;
            foreach (seg_base[s]) begin
                seg_base[s]       = '0;
                seg_mem_size[s]   = '0;
                seg_file_size[s]  = '0;
                seg_file_start[s] = '0;
                seg_perm[s]       = '0;
                foreach (page_mapped[s][p]) page_mapped[s][p] = 1'b0;
            end
            errors   = 0;
            loads    = 0;
            maps     = 0;
            invalids = 0;
        endfunction

        // works out the response to one request and updates the mirrored state
        function t_rsp resolve_request(t_req r);
            t_rsp            res;
            int unsigned     count;
            int unsigned     pg;
            bit [ADDR_W-1:0] off;
            longint unsigned page_off, fs, ms, left, rd, zr, room, used, mem_left;
            res = '0;
            if (r.operation == OP_LOAD) begin
                seg_base[r.segment_slot]       = r.address;
                seg_mem_size[r.segment_slot]   = r.mem_bytes;
                seg_file_size[r.segment_slot]  = r.file_bytes;
                seg_file_start[r.segment_slot] = r.file_start;
                seg_perm[r.segment_slot]       = r.access_perm;
                for (int p = 0; p < PAGES_PER_SEGMENT; p++) page_mapped[r.segment_slot][p] = 1'b0;
                res.verdict     = VERDICT_LOADED;
                res.segment_hit = r.segment_slot;
                loads++;
                return res;
            end
            count = (segments_in_use > NUM_SEGMENTS) ? NUM_SEGMENTS : segments_in_use;
            // first segment in slot order whose range holds the address
            for (int s = 0; s < count; s++) begin
                if (r.address < seg_base[s]) continue;
                off = r.address - seg_base[s];
                if (off >= 32'(seg_mem_size[s])) continue;
                res.segment_hit = SLOT_W'(s);
                pg = off / PAGE_BYTES;
                if (pg >= PAGES_PER_SEGMENT || page_mapped[s][pg]) begin
                    res.verdict = VERDICT_INVALID;
                    invalids++;
                    return res;
                end
                page_mapped[s][pg] = 1'b1;
                page_off = longint'(pg) * PAGE_BYTES;
                fs = seg_file_size[s];
                ms = seg_mem_size[s];
                rd = 0;
                if (fs > page_off) begin
                    left = fs - page_off;
                    rd = (left > PAGE_BYTES) ? PAGE_BYTES : left;
                    res.file_position = seg_file_start[s] + ADDR_W'(page_off);
                    zr = 0;
                    // partial page of file data, then zero fill up to the memory end
                    if (rd < PAGE_BYTES) begin
                        room = PAGE_BYTES - rd;
                        used = page_off + rd;
                        mem_left = (ms > used) ? ms - used : 0;
                        zr = (room > mem_left) ? mem_left : room;
                    end
                end else begin
                    mem_left = ms - page_off;
                    zr = (mem_left > PAGE_BYTES) ? PAGE_BYTES : mem_left;
                end
                res.verdict      = VERDICT_MAP;
                res.page_address = seg_base[s] + ADDR_W'(page_off);
                res.read_bytes   = BYTES_W'(rd);
                res.zero_bytes   = BYTES_W'(zr);
                res.page_perm    = seg_perm[s];
                maps++;
                return res;
            end
            res.verdict = VERDICT_INVALID;
            invalids++;
            return res;
        endfunction

        function void note_request(t_req r);
            awaited_rsp.push_back(resolve_request(r));
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (awaited_rsp.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("%0t: response %h with no request outstanding", $time, got);
                errors++;
                return;
            end
            want = awaited_rsp.pop_front();
            compare_field("verdict", 32'(want.verdict), 32'(got.verdict));
            compare_field("segment_hit", 32'(want.segment_hit), 32'(got.segment_hit));
            compare_field("page_address", want.page_address, got.page_address);
            compare_field("file_position", want.file_position, got.file_position);
            compare_field("read_bytes", 32'(want.read_bytes), 32'(got.read_bytes));
            compare_field("zero_bytes", 32'(want.zero_bytes), 32'(got.zero_bytes));
            compare_field("page_perm", 32'(want.page_perm), 32'(got.page_perm));
        endfunction

        function int pending();
            return awaited_rsp.size();
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;

    dpfr_stream_if #(.T(t_req)) req_if ();
    dpfr_stream_if #(.T(t_rsp)) rsp_if ();

    paging_scoreboard sb = new();

    int req_idle_pct;
    int rsp_idle_pct;
    int rsp_hold_request;
    int cfg_writes;

    int phase_cfg [PHASES] = '{8, 15, 0, 3, 1, 9, 8, 4, 12, 6, 2, 7};

    demand_paging_fault_resolver_unit #(
        .NUM_SEGMENTS      (NUM_SEGMENTS),
        .PAGE_BYTES        (PAGE_BYTES),
        .PAGES_PER_SEGMENT (PAGES_PER_SEGMENT)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    // clock
    always #5 i_clk = ~i_clk;

    function automatic t_req load_req(int unsigned slot, bit [31:0] base, int unsigned mem,
                                      int unsigned file, bit [31:0] fstart, int unsigned perm);
        t_req r;
        r.operation    = OP_LOAD;
        r.segment_slot = SLOT_W'(slot);
        r.address      = base;
        r.mem_bytes    = SZ_W'(mem);
        r.file_bytes   = SZ_W'(file);
        r.file_start   = fstart;
        r.access_perm  = PERM_W'(perm);
        return r;
    endfunction

    function automatic t_req fault_req(bit [31:0] addr);
        t_req r;
        r = '0;
        r.operation = OP_FAULT;
        r.address   = addr;
        return r;
    endfunction

    // random descriptor load: bases near the ends, shared bases, small and full sizes
    function automatic t_req make_load();
        bit [31:0]   base;
        int unsigned mem;
        int unsigned file;
        case ($urandom_range(4))
            0: base = $urandom;
            1: base = 32'hFFFF_FFFF - $urandom_range(32'h3FFF);
            2: base = sb.seg_base[$urandom_range(NUM_SEGMENTS - 1)];
            3: base = $urandom_range(32'hFFFF);
            default: base = $urandom & 32'hFFFF_F000;
        endcase
        case ($urandom_range(5))
            0: mem = 0;
            1: mem = MAX_SEG_BYTES;
            2: mem = $urandom_range(MAX_SEG_BYTES, 1);
            default: mem = $urandom_range(4 * PAGE_BYTES, 1);
        endcase
        case ($urandom_range(4))
            0: file = 0;
            1: file = mem;
            2: file = $urandom_range(mem, 0);
            3: file = $urandom_range(MAX_SEG_BYTES, 0);
            default: begin
                file = mem + $urandom_range(2 * PAGE_BYTES, 1);
                if (file > MAX_SEG_BYTES) file = MAX_SEG_BYTES;
            end
        endcase
        return load_req($urandom_range(NUM_SEGMENTS - 1), base, mem, file, $urandom,
                        $urandom_range(7));
    endfunction

    // random fault: mostly inside a loaded segment, the rest at edges or anywhere
    function automatic t_req make_fault();
        t_req        r;
        int unsigned s;
        bit [31:0]   base;
        bit [31:0]   mem;
        s    = $urandom_range(NUM_SEGMENTS - 1);
        base = sb.seg_base[s];
        mem  = 32'(sb.seg_mem_size[s]);
        r.operation    = OP_FAULT;
        r.segment_slot = SLOT_W'($urandom);
        r.mem_bytes    = SZ_W'($urandom);
        r.file_bytes   = SZ_W'($urandom);
        r.file_start   = $urandom;
        r.access_perm  = PERM_W'($urandom);
        if ($urandom_range(99) < 75 && mem != 0) begin
            r.address = base + $urandom_range(mem - 1);
        end else begin
            case ($urandom_range(4))
                0: r.address = base - 1;
                1: r.address = base + mem;
                2: r.address = '0;
                3: r.address = 32'hFFFF_FFFF;
                default: r.address = $urandom;
            endcase
        end
        return r;
    endfunction

    // offer one request, with random idle cycles first, and note it once accepted
    task automatic send_item(input t_req r);
        while ($urandom_range(99) < req_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(r);
    endtask

    // stop offering and wait for every awaited response
    task automatic drain_responses();
        req_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_segments_in_use(input int unsigned value);
        drain_responses();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.segments_in_use = CFG_W'(value);
        cfg_writes++;
    endtask

    // response side: check accepted responses, random or long hold-off on ready
    initial begin : response_sink
        int stall_left;
        stall_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
            if (rsp_hold_request != 0) begin
                stall_left = rsp_hold_request;
                rsp_hold_request = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
            end
        end
    end

    // watchdog on cycles without any accepted request or response
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) quiet = 0;
            else quiet++;
        end
        $display("%0t: nothing accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_wdata  <= '0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        req_idle_pct     = 0;
        rsp_idle_pct     = 0;
        rsp_hold_request = 0;
        cfg_writes       = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill every slot while no segment is scanned
        send_item(load_req(0, 32'h0000_0000, MAX_SEG_BYTES, 32'h10_0800, 32'hFFFF_F800, 7));
        send_item(load_req(1, 32'hFFFF_F000, 32'h2000, 32'h1000, 32'h1234_5000, 5));
        send_item(load_req(2, 32'h0020_0000, 0, 32'h800, 32'h0, 1));
        send_item(load_req(3, 32'h4000_0000, 32'h3000, 32'h3000, 32'h0001_0000, 2));
        send_item(load_req(4, 32'h4000_0000, 32'h5000, 32'h1000, 32'h0002_0000, 3));
        send_item(load_req(5, 32'h5000_0000, 32'h2200, 32'h2400, 32'h7FFF_F000, 4));
        send_item(load_req(6, 32'h6000_0000, 32'h1234, 0, 32'hABCD_E000, 6));
        send_item(load_req(7, 32'h8000_0000, 1, 1, 32'hFFFF_FFFF, 0));

        // directed faults: first page, remap, last page with file offset wrap, misses,
        // top of address space, shadowed segment, no file data, file larger than memory
        write_segments_in_use(NUM_SEGMENTS);
        send_item(fault_req(32'h0000_0000));
        send_item(fault_req(32'h0000_0000));
        send_item(fault_req(32'h000F_FFFF));
        send_item(fault_req(32'h0010_0000));
        send_item(fault_req(32'hFFFF_FFFF));
        send_item(fault_req(32'h4000_2FFF));
        send_item(fault_req(32'h4000_4000));
        send_item(fault_req(32'h5000_2100));
        send_item(fault_req(32'h6000_1000));
        send_item(fault_req(32'h8000_0000));
        send_item(fault_req(32'h0020_0000));
        // reload clears the slot's mapped pages
        send_item(load_req(0, 32'h0000_0000, MAX_SEG_BYTES, 32'h10_0800, 32'hFFFF_F800, 7));
        send_item(fault_req(32'h0000_0FFF));
        // no segment scanned, then a count above the table
        write_segments_in_use(0);
        send_item(fault_req(32'h4000_0000));
        write_segments_in_use(15);
        send_item(fault_req(32'h4000_0000));

        // random phases over register settings and idle mixes
        for (int ph = 0; ph < PHASES; ph++) begin
            write_segments_in_use(phase_cfg[ph]);
            if (ph < 4) begin
                req_idle_pct = 18;
                rsp_idle_pct = 59;
            end else if (ph < 8) begin
                req_idle_pct = 59;
                rsp_idle_pct = 18;
            end else begin
                req_idle_pct = 0;
                rsp_idle_pct = 0;
            end
            // long response hold-off while requests keep coming
            if (ph == 9) rsp_hold_request = LONG_HOLD_CYCLES;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 10 && n == PHASE_ITEMS / 2) drain_responses();
                if ($urandom_range(99) < 18) send_item(make_load());
                else send_item(make_fault());
            end
        end

        drain_responses();
        repeat (300) @(posedge i_clk);
        $display("covered %0d descriptor loads, %0d mapped pages, %0d invalid faults",
                 sb.loads, sb.maps, sb.invalids);
        $display("over %0d segment count settings, with idle, stall and drain periods",
                 cfg_writes);
        if (sb.errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule
